>>> hw/rtl/sgrt_pkg.sv
// Shared constants, types and the SGR code decoder for the style tracker.
`default_nettype none

package sgrt_pkg;

   localparam int unsigned ATTR_BITS     = 4;
   localparam int unsigned BASE_BITS     = 12;
   localparam int unsigned CFG_PAIR_BITS = 8;
   localparam int unsigned PAIR_SLOTS    = 7;
   localparam int unsigned SLOT_BITS     = 3;
   localparam int unsigned NUM_BITS      = 10;
   localparam int unsigned ADDR_BITS     = 5;
   localparam int unsigned DATA_BITS     = 32;

   localparam logic [NUM_BITS-1:0] NUM_MAX = 10'd1023;

   localparam logic [7:0] CHAR_ZERO = 8'h30;
   localparam logic [7:0] CHAR_NINE = 8'h39;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;
   localparam logic [7:0] CHAR_M    = 8'h6D;

   // Register indexes on the configuration port.
   localparam logic [2:0] REG_BASE    = 3'd0;
   localparam logic [2:0] REG_TEXT    = 3'd1;
   localparam logic [2:0] REG_CODE    = 3'd2;
   localparam logic [2:0] REG_QUOTE   = 3'd3;
   localparam logic [2:0] REG_ALARM   = 3'd4;
   localparam logic [2:0] REG_STRING  = 3'd5;
   localparam logic [2:0] REG_COMMENT = 3'd6;
   localparam logic [2:0] REG_KEYWORD = 3'd7;

   // Pair slots: register index minus one.
   localparam logic [SLOT_BITS-1:0] SLOT_TEXT    = 3'd0;
   localparam logic [SLOT_BITS-1:0] SLOT_CODE    = 3'd1;
   localparam logic [SLOT_BITS-1:0] SLOT_QUOTE   = 3'd2;
   localparam logic [SLOT_BITS-1:0] SLOT_ALARM   = 3'd3;
   localparam logic [SLOT_BITS-1:0] SLOT_STRING  = 3'd4;
   localparam logic [SLOT_BITS-1:0] SLOT_COMMENT = 3'd5;
   localparam logic [SLOT_BITS-1:0] SLOT_KEYWORD = 3'd6;

   localparam logic [ATTR_BITS-1:0] ATTR_BOLD      = 4'b0001;
   localparam logic [ATTR_BITS-1:0] ATTR_DIM       = 4'b0010;
   localparam logic [ATTR_BITS-1:0] ATTR_ITALIC    = 4'b0100;
   localparam logic [ATTR_BITS-1:0] ATTR_UNDERLINE = 4'b1000;

   // SGR codes.
   localparam logic [NUM_BITS-1:0] SGR_RESET        = 10'd0;
   localparam logic [NUM_BITS-1:0] SGR_BOLD         = 10'd1;
   localparam logic [NUM_BITS-1:0] SGR_DIM          = 10'd2;
   localparam logic [NUM_BITS-1:0] SGR_ITALIC       = 10'd3;
   localparam logic [NUM_BITS-1:0] SGR_UNDERLINE    = 10'd4;
   localparam logic [NUM_BITS-1:0] SGR_NORMAL       = 10'd22;
   localparam logic [NUM_BITS-1:0] SGR_NO_ITALIC    = 10'd23;
   localparam logic [NUM_BITS-1:0] SGR_NO_UNDERLINE = 10'd24;
   localparam logic [NUM_BITS-1:0] SGR_FG_BLACK     = 10'd30;
   localparam logic [NUM_BITS-1:0] SGR_FG_RED       = 10'd31;
   localparam logic [NUM_BITS-1:0] SGR_FG_GREEN     = 10'd32;
   localparam logic [NUM_BITS-1:0] SGR_FG_YELLOW    = 10'd33;
   localparam logic [NUM_BITS-1:0] SGR_FG_BLUE      = 10'd34;
   localparam logic [NUM_BITS-1:0] SGR_FG_MAGENTA   = 10'd35;
   localparam logic [NUM_BITS-1:0] SGR_FG_CYAN      = 10'd36;
   localparam logic [NUM_BITS-1:0] SGR_FG_WHITE     = 10'd37;
   localparam logic [NUM_BITS-1:0] SGR_BR_BLACK     = 10'd90;
   localparam logic [NUM_BITS-1:0] SGR_BR_RED       = 10'd91;
   localparam logic [NUM_BITS-1:0] SGR_BR_GREEN     = 10'd92;
   localparam logic [NUM_BITS-1:0] SGR_BR_YELLOW    = 10'd93;
   localparam logic [NUM_BITS-1:0] SGR_BR_BLUE      = 10'd94;
   localparam logic [NUM_BITS-1:0] SGR_BR_MAGENTA   = 10'd95;
   localparam logic [NUM_BITS-1:0] SGR_BR_CYAN      = 10'd96;
   localparam logic [NUM_BITS-1:0] SGR_BR_WHITE     = 10'd97;

   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_BASE,
      ACT_SET,
      ACT_CLEAR,
      ACT_PAIR
   } sgr_act_type;

   typedef struct packed {
      sgr_act_type           act;
      logic [ATTR_BITS-1:0]  mask;
      logic [SLOT_BITS-1:0]  slot;
   } sgr_decode_type;

   typedef struct packed {
      logic [BASE_BITS-1:0]                         base;
      logic [PAIR_SLOTS-1:0][CFG_PAIR_BITS-1:0]     pair;
   } csr_regs_type;

   function automatic sgr_decode_type decode_sgr(input logic [NUM_BITS-1:0] code);
      sgr_decode_type d;
      d.act  = ACT_NONE;
      d.mask = '0;
      d.slot = SLOT_TEXT;
      unique case (code) inside
         SGR_RESET: d.act = ACT_BASE;
         SGR_BOLD: begin
            d.act  = ACT_SET;
            d.mask = ATTR_BOLD;
         end
         SGR_DIM: begin
            d.act  = ACT_SET;
            d.mask = ATTR_DIM;
         end
         SGR_ITALIC: begin
            d.act  = ACT_SET;
            d.mask = ATTR_ITALIC;
         end
         SGR_UNDERLINE: begin
            d.act  = ACT_SET;
            d.mask = ATTR_UNDERLINE;
         end
         SGR_NORMAL: begin
            d.act  = ACT_CLEAR;
            d.mask = ATTR_BOLD | ATTR_DIM;
         end
         SGR_NO_ITALIC: begin
            d.act  = ACT_CLEAR;
            d.mask = ATTR_ITALIC;
         end
         SGR_NO_UNDERLINE: begin
            d.act  = ACT_CLEAR;
            d.mask = ATTR_UNDERLINE;
         end
         SGR_FG_BLACK, SGR_FG_WHITE, SGR_BR_BLACK, SGR_BR_WHITE: begin
            d.act  = ACT_PAIR;
            d.slot = SLOT_TEXT;
         end
         SGR_FG_GREEN, SGR_BR_GREEN: begin
            d.act  = ACT_PAIR;
            d.slot = SLOT_CODE;
         end
         SGR_FG_CYAN, SGR_BR_CYAN: begin
            d.act  = ACT_PAIR;
            d.slot = SLOT_QUOTE;
         end
         SGR_FG_RED, SGR_BR_RED: begin
            d.act  = ACT_PAIR;
            d.slot = SLOT_ALARM;
         end
         SGR_FG_YELLOW, SGR_BR_YELLOW: begin
            d.act  = ACT_PAIR;
            d.slot = SLOT_STRING;
         end
         SGR_FG_BLUE, SGR_BR_BLUE: begin
            d.act  = ACT_PAIR;
            d.slot = SLOT_COMMENT;
         end
         SGR_FG_MAGENTA, SGR_BR_MAGENTA: begin
            d.act  = ACT_PAIR;
            d.slot = SLOT_KEYWORD;
         end
         default: d.act = ACT_NONE;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/sgrt_req_if.sv
// Request channel: one escape-sequence byte with its framing flags.
`default_nettype none

interface sgrt_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       start_seq;
   logic       end_of_text;

   modport source (output valid, output text_byte, output start_seq, output end_of_text,
                   input ready);
   modport sink   (input valid, input text_byte, input start_seq, input end_of_text,
                   output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sgrt_rsp_if.sv
// Result channel: text style after one byte and the end-of-sequence flag.
`default_nettype none

interface sgrt_rsp_if;
   logic       valid;
   logic       ready;
   logic       bold;
   logic       dim;
   logic       italic;
   logic       underline;
   logic [7:0] color_pair;
   logic       seq_done;

   modport source (output valid, output bold, output dim, output italic, output underline,
                   output color_pair, output seq_done, input ready);
   modport sink   (input valid, input bold, input dim, input italic, input underline,
                   input color_pair, input seq_done, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/sgrt_csr.sv
// APB-style configuration registers: base style and the seven color pairs.
`default_nettype none

module sgrt_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [sgrt_pkg::ADDR_BITS-1:0] paddr,
   input  wire logic [sgrt_pkg::DATA_BITS-1:0] pwdata,
   output logic      [sgrt_pkg::DATA_BITS-1:0] prdata,
   output logic                                pready,
   output sgrt_pkg::csr_regs_type              regs
);

   sgrt_pkg::csr_regs_type regs_ff;
   sgrt_pkg::csr_regs_type regs_in;
   logic [2:0]             reg_idx;
   logic [2:0]             slot_idx;
   logic                   wr_en;

   assign pready   = 1'b1;
   assign reg_idx  = paddr[4:2];
   assign slot_idx = 3'(reg_idx - sgrt_pkg::REG_TEXT);
   assign wr_en    = psel && penable && pwrite;

   always_comb begin
      regs_in = regs_ff;
      if (wr_en) begin
         unique case (reg_idx)
            sgrt_pkg::REG_BASE: regs_in.base = pwdata[sgrt_pkg::BASE_BITS-1:0];
            default:            regs_in.pair[slot_idx] = pwdata[sgrt_pkg::CFG_PAIR_BITS-1:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   always_comb begin
      unique case (reg_idx)
         sgrt_pkg::REG_BASE: prdata = sgrt_pkg::DATA_BITS'(regs_ff.base);
         default:            prdata = sgrt_pkg::DATA_BITS'(regs_ff.pair[slot_idx]);
      endcase
   end

   assign regs = regs_ff;

endmodule

`default_nettype wire

>>> hw/rtl/sgr_escape_style_tracker.sv
// Top level: SGR escape parser that tracks the running text style.
// Pipeline: input register, then the style update into the result register.
// Throughput: one request per cycle unless results back up; the style and number
// state loop closes in the single update stage; bytes never wait on each other.
// Reset (synchronous, active high): style, number state, registers and both
// pipeline valid flags clear; there is no clearing pass.
`default_nettype none

module sgr_escape_style_tracker #(
   parameter int unsigned PAIR_BITS = 8
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   sgrt_req_if.sink                            req_bus,
   sgrt_rsp_if.source                          rsp_bus,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [sgrt_pkg::ADDR_BITS-1:0] paddr,
   input  wire logic [sgrt_pkg::DATA_BITS-1:0] pwdata,
   output logic      [sgrt_pkg::DATA_BITS-1:0] prdata,
   output logic                                pready
);

   localparam int unsigned NB = sgrt_pkg::NUM_BITS;
   localparam int unsigned AB = sgrt_pkg::ATTR_BITS;
   // Room for accum * 10 + 9 without overflow.
   localparam int unsigned PROD_BITS = NB + 4;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       start_seq;
      logic       end_of_text;
   } req_item_type;

   sgrt_pkg::csr_regs_type regs;

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   sgrt_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .regs    (regs)
   );

   // ------------------------------------------------------------------
   // Handshake and pipeline valids
   // ------------------------------------------------------------------
   logic          s1_valid_ff, s1_valid_in;
   req_item_type  s1_item_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          req_fire;
   logic          advance;

   // Advance the update stage whenever the result register is free or draining.
   assign advance      = s1_valid_ff && (!rsp_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !s1_valid_ff || advance;
   assign req_fire     = req_bus.valid && req_bus.ready;
   assign s1_valid_in  = req_fire || (s1_valid_ff && !advance);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Capture the request payload; hold it while the stage is stalled.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_item_ff.text_byte   <= req_bus.text_byte;
         s1_item_ff.start_seq   <= req_bus.start_seq;
         s1_item_ff.end_of_text <= req_bus.end_of_text;
      end
   end

   // ------------------------------------------------------------------
   // Parser state
   // ------------------------------------------------------------------
   logic [AB-1:0]        attr_ff, attr_in;
   logic [PAIR_BITS-1:0] pair_ff, pair_in;
   logic [NB-1:0]        accum_ff, accum_in;
   logic                 pend_ff, pend_in;
   logic                 applied_ff, applied_in;
   logic                 in_seq_ff, in_seq_in;

   logic                     active;
   logic [NB-1:0]            accum_cur;
   logic                     pend_cur;
   logic                     applied_cur;
   logic                     is_digit, is_semi, is_m;
   logic [3:0]               digit_val;
   logic [PROD_BITS-1:0]     accum_next;
   logic [NB-1:0]            accum_sat;
   logic                     ends_seq;
   logic                     done;
   logic                     apply_en;
   logic [NB-1:0]            code;
   sgrt_pkg::sgr_decode_type dec;

   always_comb begin
      // A start byte abandons whatever sequence was open.
      active      = s1_item_ff.start_seq || in_seq_ff;
      accum_cur   = s1_item_ff.start_seq ? '0   : accum_ff;
      pend_cur    = s1_item_ff.start_seq ? 1'b0 : pend_ff;
      applied_cur = s1_item_ff.start_seq ? 1'b0 : applied_ff;

      is_digit  = (s1_item_ff.text_byte >= sgrt_pkg::CHAR_ZERO) &&
                  (s1_item_ff.text_byte <= sgrt_pkg::CHAR_NINE);
      is_semi   = (s1_item_ff.text_byte == sgrt_pkg::CHAR_SEMI);
      is_m      = (s1_item_ff.text_byte == sgrt_pkg::CHAR_M);
      digit_val = 4'(s1_item_ff.text_byte - sgrt_pkg::CHAR_ZERO);

      // accum * 10 + digit, saturating.
      accum_next = (PROD_BITS'(accum_cur) << 3) + (PROD_BITS'(accum_cur) << 1)
                   + PROD_BITS'(digit_val);
      accum_sat  = (accum_next > PROD_BITS'(sgrt_pkg::NUM_MAX)) ? sgrt_pkg::NUM_MAX
                                                                 : NB'(accum_next);

      accum_in   = accum_cur;
      pend_in    = pend_cur;
      applied_in = applied_cur;
      in_seq_in  = in_seq_ff;
      ends_seq   = 1'b0;
      done       = 1'b0;
      apply_en   = 1'b0;
      code       = sgrt_pkg::SGR_RESET;

      if (active) begin
         in_seq_in = 1'b1;
         if (is_digit) begin
            accum_in = accum_sat;
            pend_in  = 1'b1;
         end else if (is_semi) begin
            // Empty parameter counts as code 0.
            apply_en = 1'b1;
            code     = pend_cur ? accum_cur : sgrt_pkg::SGR_RESET;
            accum_in = '0;
            pend_in  = 1'b0;
         end else if (is_m) begin
            apply_en = pend_cur;
            code     = accum_cur;
            ends_seq = 1'b1;
         end else begin
            // Any other byte aborts: drop the pending number.
            ends_seq = 1'b1;
         end

         done = ends_seq || s1_item_ff.end_of_text;

         if (done) begin
            // A sequence that applied nothing restores the base style.
            if (!(applied_cur || apply_en)) begin
               apply_en = 1'b1;
               code     = sgrt_pkg::SGR_RESET;
            end
            in_seq_in  = 1'b0;
            accum_in   = '0;
            pend_in    = 1'b0;
            applied_in = 1'b0;
         end else begin
            applied_in = applied_cur || apply_en;
         end
      end
   end

   // Apply the selected code to the style.
   always_comb begin
      dec     = sgrt_pkg::decode_sgr(code);
      attr_in = attr_ff;
      pair_in = pair_ff;
      if (apply_en) begin
         unique case (dec.act)
            sgrt_pkg::ACT_BASE: begin
               attr_in = regs.base[AB-1:0];
               pair_in = PAIR_BITS'(regs.base[sgrt_pkg::BASE_BITS-1:AB]);
            end
            sgrt_pkg::ACT_SET:   attr_in = attr_ff | dec.mask;
            sgrt_pkg::ACT_CLEAR: attr_in = attr_ff & ~dec.mask;
            sgrt_pkg::ACT_PAIR:  pair_in = PAIR_BITS'(regs.pair[dec.slot]);
            default: begin
               attr_in = attr_ff;
               pair_in = pair_ff;
            end
         endcase
      end
   end

   // Commit the state only when the byte moves into the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff    <= '0;
         pair_ff    <= '0;
         accum_ff   <= '0;
         pend_ff    <= 1'b0;
         applied_ff <= 1'b0;
         in_seq_ff  <= 1'b0;
      end else if (advance) begin
         attr_ff    <= attr_in;
         pair_ff    <= pair_in;
         accum_ff   <= accum_in;
         pend_ff    <= pend_in;
         applied_ff <= applied_in;
         in_seq_ff  <= in_seq_in;
      end
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   logic [AB-1:0] rsp_attr_ff;
   logic [7:0]    rsp_pair_ff;
   logic          rsp_done_ff;

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_attr_ff <= attr_in;
         rsp_pair_ff <= 8'(pair_in);
         rsp_done_ff <= done;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.bold       = rsp_attr_ff[0];
   assign rsp_bus.dim        = rsp_attr_ff[1];
   assign rsp_bus.italic     = rsp_attr_ff[2];
   assign rsp_bus.underline  = rsp_attr_ff[3];
   assign rsp_bus.color_pair = rsp_pair_ff;
   assign rsp_bus.seq_done   = rsp_done_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   // Outside a sequence no number state may linger.
   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !in_seq_ff |-> (!pend_ff && !applied_ff && accum_ff == '0))
      else $error("number state left over outside a sequence");

   // The accumulator only holds a value while digits are pending.
   a_accum_pending: assert property (@(posedge clock) disable iff (reset)
      !pend_ff |-> (accum_ff == '0))
      else $error("accumulator nonzero with no digits pending");

   // A byte that leaves the update stage always lands in the result register.
   a_advance_loads: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced byte did not produce a result");

   // An accepted request is held in the update stage on the next cycle.
   a_req_held: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> s1_valid_ff)
      else $error("accepted request lost");

endmodule

`default_nettype wire

>>> tb/sgr_escape_style_tracker_tb.sv
// Testbench for the SGR escape style tracker: directed table, random sequences, style predictor.
`timescale 1ns / 100ps

module sgr_escape_style_tracker_tb;

   // Stop the run after this long no matter what; several times the slowest legal run.
   localparam int unsigned LIMIT_NS        = 3_000_000;
   localparam int unsigned RESET_CYCLES    = 6;
   // Settle time after the last result; a request passes the input and result registers.
   localparam int unsigned SETTLE_CYCLES   = 4;
   localparam int unsigned PHASES          = 6;
   // Sequence bytes per phase; noise outside a sequence is not counted.
   localparam int unsigned PHASE_ITEMS     = 225;
   localparam int unsigned HOLD_CYCLES     = 300;
   localparam int unsigned REPORT_LIMIT    = 10;
   localparam int unsigned NUM_REGS        = sgrt_pkg::REG_KEYWORD + 1;
   localparam int unsigned DIRECTED_CFG_ROW = 3;

   typedef struct packed {
      logic [sgrt_pkg::CFG_PAIR_BITS-1:0] pair;
      logic                               underline;
      logic                               italic;
      logic                               dim;
      logic                               bold;
   } text_style_type;

   typedef struct packed {
      logic           seq_done;
      text_style_type style;
   } style_result_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       start_seq;
      logic       end_of_text;
   } text_req_type;

   typedef struct packed {
      text_req_type     req;
      logic             typed;
      style_result_type want;
   } directed_row_type;

   // Every code the block acts on; random parameters draw from here most of the time.
   localparam logic [sgrt_pkg::NUM_BITS-1:0] KNOWN_CODES [0:23] = '{
      sgrt_pkg::SGR_RESET, sgrt_pkg::SGR_BOLD, sgrt_pkg::SGR_DIM, sgrt_pkg::SGR_ITALIC,
      sgrt_pkg::SGR_UNDERLINE, sgrt_pkg::SGR_NORMAL, sgrt_pkg::SGR_NO_ITALIC,
      sgrt_pkg::SGR_NO_UNDERLINE,
      sgrt_pkg::SGR_FG_BLACK, sgrt_pkg::SGR_FG_RED, sgrt_pkg::SGR_FG_GREEN,
      sgrt_pkg::SGR_FG_YELLOW, sgrt_pkg::SGR_FG_BLUE, sgrt_pkg::SGR_FG_MAGENTA,
      sgrt_pkg::SGR_FG_CYAN, sgrt_pkg::SGR_FG_WHITE,
      sgrt_pkg::SGR_BR_BLACK, sgrt_pkg::SGR_BR_RED, sgrt_pkg::SGR_BR_GREEN,
      sgrt_pkg::SGR_BR_YELLOW, sgrt_pkg::SGR_BR_BLUE, sgrt_pkg::SGR_BR_MAGENTA,
      sgrt_pkg::SGR_BR_CYAN, sgrt_pkg::SGR_BR_WHITE
   };

   // Directed requests. Rows 0-2 run with the reset configuration; the rest run after the
   // registers get the directed values below (base 3C5: bold, italic, pair 3C).
   localparam directed_row_type DIRECTED_ROWS [0:25] = '{
      '{'{"A",   1'b0, 1'b0}, 1'b1, '{1'b0, 12'h000}}, // outside a sequence: no change
      '{'{"m",   1'b1, 1'b0}, 1'b1, '{1'b1, 12'h000}}, // empty sequence restores base
      '{'{8'hFF, 1'b0, 1'b1}, 1'b1, '{1'b0, 12'h000}}, // end of text outside: no done
      '{'{"x",   1'b1, 1'b0}, 1'b1, '{1'b1, 12'h3C5}}, // stray byte ends, base applied
      '{'{"1",   1'b1, 1'b0}, 1'b0, '0},
      '{'{";",   1'b0, 1'b0}, 1'b0, '0},
      '{'{"2",   1'b0, 1'b0}, 1'b0, '0},
      '{'{";",   1'b0, 1'b0}, 1'b0, '0},
      '{'{"4",   1'b0, 1'b0}, 1'b0, '0},
      '{'{"m",   1'b0, 1'b0}, 1'b0, '0},
      '{'{"9",   1'b1, 1'b0}, 1'b0, '0},
      '{'{"7",   1'b0, 1'b0}, 1'b0, '0},
      '{'{";",   1'b0, 1'b0}, 1'b0, '0},
      '{'{"3",   1'b0, 1'b0}, 1'b0, '0},
      '{'{"5",   1'b0, 1'b1}, 1'b0, '0},          // end of text drops the pending 35
      '{'{"9",   1'b1, 1'b0}, 1'b0, '0},
      '{'{"9",   1'b0, 1'b0}, 1'b0, '0},
      '{'{"9",   1'b0, 1'b0}, 1'b0, '0},
      '{'{"9",   1'b0, 1'b0}, 1'b0, '0},          // saturates at the number ceiling
      '{'{"m",   1'b0, 1'b0}, 1'b0, '0},
      '{'{"3",   1'b1, 1'b0}, 1'b0, '0},
      '{'{"1",   1'b0, 1'b0}, 1'b0, '0},
      '{'{"2",   1'b1, 1'b0}, 1'b0, '0},          // restart abandons the open 31
      '{'{"m",   1'b0, 1'b0}, 1'b0, '0},
      '{'{";",   1'b1, 1'b1}, 1'b0, '0},          // empty parameter, then end of text
      '{'{"0",   1'b0, 1'b0}, 1'b0, '0}
   };

   logic                           clock = 1'b0;
   logic                           reset = 1'b1;
   logic                           psel;
   logic                           penable;
   logic                           pwrite;
   logic [sgrt_pkg::ADDR_BITS-1:0] paddr;
   logic [sgrt_pkg::DATA_BITS-1:0] pwdata;
   logic [sgrt_pkg::DATA_BITS-1:0] prdata;
   logic                           pready;

   sgrt_req_if req_bus ();
   sgrt_rsp_if rsp_bus ();

   sgr_escape_style_tracker #(
      .PAIR_BITS (sgrt_pkg::CFG_PAIR_BITS)
   ) u_top (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predicted style after each accepted request, oldest first.
   style_result_type pending_styles [$];
   int unsigned      mismatch_count = 0;

   // Predictor copy of the block's registers and parse state.
   text_style_type                     base_style_cfg = '0;
   logic [sgrt_pkg::CFG_PAIR_BITS-1:0] pair_cfg [sgrt_pkg::REG_TEXT:sgrt_pkg::REG_KEYWORD] =
      '{default: '0};
   text_style_type                     cur_style      = '0;
   logic [sgrt_pkg::NUM_BITS-1:0]      number_acc     = '0;
   logic                               digits_seen    = 1'b0;
   logic                               code_seen      = 1'b0;
   logic                               seq_open       = 1'b0;

   // Sender pacing and the receiver hold-off request.
   logic        offering    = 1'b0;
   int unsigned burst_left  = 8;
   logic        hold_off_req = 1'b0;

   // ---------------------------------------------------------------- predictor

   function automatic void apply_sgr_code(input logic [sgrt_pkg::NUM_BITS-1:0] code);
      code_seen = 1'b1;
      case (code) inside
         sgrt_pkg::SGR_RESET:        cur_style = base_style_cfg;
         sgrt_pkg::SGR_BOLD:         cur_style.bold = 1'b1;
         sgrt_pkg::SGR_DIM:          cur_style.dim = 1'b1;
         sgrt_pkg::SGR_ITALIC:       cur_style.italic = 1'b1;
         sgrt_pkg::SGR_UNDERLINE:    cur_style.underline = 1'b1;
         sgrt_pkg::SGR_NORMAL: begin
            cur_style.bold = 1'b0;
            cur_style.dim  = 1'b0;
         end
         sgrt_pkg::SGR_NO_ITALIC:    cur_style.italic = 1'b0;
         sgrt_pkg::SGR_NO_UNDERLINE: cur_style.underline = 1'b0;
         sgrt_pkg::SGR_FG_BLACK, sgrt_pkg::SGR_FG_WHITE,
         sgrt_pkg::SGR_BR_BLACK, sgrt_pkg::SGR_BR_WHITE:
            cur_style.pair = pair_cfg[sgrt_pkg::REG_TEXT];
         sgrt_pkg::SGR_FG_GREEN, sgrt_pkg::SGR_BR_GREEN:
            cur_style.pair = pair_cfg[sgrt_pkg::REG_CODE];
         sgrt_pkg::SGR_FG_CYAN, sgrt_pkg::SGR_BR_CYAN:
            cur_style.pair = pair_cfg[sgrt_pkg::REG_QUOTE];
         sgrt_pkg::SGR_FG_RED, sgrt_pkg::SGR_BR_RED:
            cur_style.pair = pair_cfg[sgrt_pkg::REG_ALARM];
         sgrt_pkg::SGR_FG_YELLOW, sgrt_pkg::SGR_BR_YELLOW:
            cur_style.pair = pair_cfg[sgrt_pkg::REG_STRING];
         sgrt_pkg::SGR_FG_BLUE, sgrt_pkg::SGR_BR_BLUE:
            cur_style.pair = pair_cfg[sgrt_pkg::REG_COMMENT];
         sgrt_pkg::SGR_FG_MAGENTA, sgrt_pkg::SGR_BR_MAGENTA:
            cur_style.pair = pair_cfg[sgrt_pkg::REG_KEYWORD];
         default: ;
      endcase
   endfunction

   // Close the sequence; a sequence that applied nothing falls back to the base style.
   function automatic void close_sequence();
      if (!code_seen)
         apply_sgr_code(sgrt_pkg::SGR_RESET);
      seq_open    = 1'b0;
      number_acc  = '0;
      digits_seen = 1'b0;
      code_seen   = 1'b0;
   endfunction

   function automatic style_result_type predict_style(input text_req_type r);
      style_result_type res;
      logic             done;
      int               acc_next;
      done = 1'b0;
      if (r.start_seq) begin
         seq_open    = 1'b1;
         number_acc  = '0;
         digits_seen = 1'b0;
         code_seen   = 1'b0;
      end
      if (seq_open) begin
         if (r.text_byte >= sgrt_pkg::CHAR_ZERO && r.text_byte <= sgrt_pkg::CHAR_NINE) begin
            acc_next    = int'(number_acc) * 10 + int'(r.text_byte)
                          - int'(sgrt_pkg::CHAR_ZERO);
            number_acc  = (acc_next > int'(sgrt_pkg::NUM_MAX)) ? sgrt_pkg::NUM_MAX
                                                                : sgrt_pkg::NUM_BITS'(acc_next);
            digits_seen = 1'b1;
         end else if (r.text_byte == sgrt_pkg::CHAR_SEMI) begin
            apply_sgr_code(digits_seen ? number_acc : sgrt_pkg::SGR_RESET);
            number_acc  = '0;
            digits_seen = 1'b0;
         end else if (r.text_byte == sgrt_pkg::CHAR_M) begin
            if (digits_seen)
               apply_sgr_code(number_acc);
            close_sequence();
            done = 1'b1;
         end else begin
            close_sequence();
            done = 1'b1;
         end
         // End of text closes whatever is still open and drops a pending number.
         if (!done && r.end_of_text) begin
            close_sequence();
            done = 1'b1;
         end
      end
      res.style    = cur_style;
      res.seq_done = done;
      return res;
   endfunction

   // ---------------------------------------------------------------- request side

   task automatic stop_offering();
      if (offering) begin
         req_bus.valid <= 1'b0;
         offering = 1'b0;
      end
   endtask

   // Advance the burst count; at the end of a burst drop valid for a random gap.
   task automatic pace_sender();
      if (burst_left > 0)
         burst_left--;
      if (burst_left == 0) begin
         stop_offering();
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                                  : $urandom_range(1, 24);
      end
   endtask

   // Offer one request and hold it until accepted; record its expected style.
   task automatic send_request(input text_req_type r, input logic typed,
                               input style_result_type want);
      style_result_type predicted;
      req_bus.valid       <= 1'b1;
      req_bus.text_byte   <= r.text_byte;
      req_bus.start_seq   <= r.start_seq;
      req_bus.end_of_text <= r.end_of_text;
      offering = 1'b1;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      predicted = predict_style(r);
      if (typed)
         predicted = want;
      pending_styles = {pending_styles, predicted};
      pace_sender();
   endtask

   // Wait for every expected result, then let the pipeline settle.
   task automatic drain_results();
      stop_offering();
      while (pending_styles.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- register port

   task automatic csr_access(input logic [2:0] idx, input logic is_write,
                             input logic [sgrt_pkg::DATA_BITS-1:0] wdata,
                             output logic [sgrt_pkg::DATA_BITS-1:0] rdata);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= is_write;
      paddr   <= {idx, 2'b00};
      pwdata  <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      rdata = prdata;
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Write every register, update the predictor copy and read each one back.
   task automatic program_registers(input logic [sgrt_pkg::DATA_BITS-1:0] values [NUM_REGS]);
      logic [sgrt_pkg::DATA_BITS-1:0] rdata;
      logic [sgrt_pkg::DATA_BITS-1:0] held;
      for (int k = sgrt_pkg::REG_BASE; k <= sgrt_pkg::REG_KEYWORD; k++) begin
         csr_access(3'(k), 1'b1, values[k], rdata);
         if (k == sgrt_pkg::REG_BASE) begin
            base_style_cfg = values[k][sgrt_pkg::BASE_BITS-1:0];
            held = sgrt_pkg::DATA_BITS'(values[k][sgrt_pkg::BASE_BITS-1:0]);
         end else begin
            pair_cfg[k] = values[k][sgrt_pkg::CFG_PAIR_BITS-1:0];
            held = sgrt_pkg::DATA_BITS'(values[k][sgrt_pkg::CFG_PAIR_BITS-1:0]);
         end
         csr_access(3'(k), 1'b0, '0, rdata);
         if (rdata !== held) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("ERROR: register %0d reads %h, expected %h", k, rdata, held);
         end
      end
   endtask

   // ---------------------------------------------------------------- random stimulus

   // One escape sequence: up to four parameters, then 'm', a stray byte, end of text,
   // or nothing at all so that the next start abandons it.
   task automatic send_random_sequence(inout int unsigned counted);
      text_req_type seq_q [$];
      logic [7:0]   digit_q [$];
      text_req_type req_next;
      int unsigned  n_params;
      int unsigned  choice;
      int unsigned  value;
      int unsigned  zeros;
      int unsigned  term;
      n_params = $urandom_range(0, 4);
      for (int p = 0; p < n_params; p++) begin
         digit_q.delete();
         choice = $urandom_range(0, 9);
         // Choice zero leaves the parameter empty.
         if (choice != 0) begin
            if (choice <= 6)
               value = KNOWN_CODES[$urandom_range(0, 23)];
            else if (choice == 7)
               value = $urandom_range(0, 120);
            else if (choice == 8)
               value = $urandom_range(0, 1023);
            else
               value = $urandom_range(1024, 999_999);
            do begin
               digit_q.push_front(sgrt_pkg::CHAR_ZERO + 8'(value % 10));
               value = value / 10;
            end while (value != 0);
            zeros = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
            repeat (zeros) digit_q.push_front(sgrt_pkg::CHAR_ZERO);
         end
         foreach (digit_q[d]) begin
            req_next = '{digit_q[d], 1'b0, 1'b0};
            seq_q = {seq_q, req_next};
         end
         if (p + 1 < n_params || $urandom_range(0, 3) == 0) begin
            req_next = '{sgrt_pkg::CHAR_SEMI, 1'b0, 1'b0};
            seq_q = {seq_q, req_next};
         end
      end
      term = $urandom_range(0, 9);
      if (term <= 6) begin
         req_next = '{sgrt_pkg::CHAR_M, 1'b0, ($urandom_range(0, 7) == 0)};
         seq_q = {seq_q, req_next};
      end else if (term == 7) begin
         req_next = '{8'($urandom), 1'b0, 1'b0};
         seq_q = {seq_q, req_next};
      end else if (term == 8) begin
         if (seq_q.size() == 0) begin
            req_next = '{sgrt_pkg::CHAR_SEMI, 1'b0, 1'b0};
            seq_q = {seq_q, req_next};
         end
         seq_q[$].end_of_text = 1'b1;
      end
      if (seq_q.size() == 0) begin
         req_next = '{sgrt_pkg::CHAR_M, 1'b0, 1'b0};
         seq_q = {seq_q, req_next};
      end
      seq_q[0].start_seq = 1'b1;
      foreach (seq_q[k]) begin
         send_request(seq_q[k], 1'b0, '0);
         counted++;
      end
   endtask

   // Bytes between sequences: mostly ignored, now and then a broken start.
   task automatic send_noise();
      text_req_type r;
      repeat ($urandom_range(1, 4)) begin
         r.text_byte   = 8'($urandom);
         r.start_seq   = ($urandom_range(0, 7) == 0);
         r.end_of_text = ($urandom_range(0, 3) == 0);
         send_request(r, 1'b0, '0);
      end
   endtask

   // ---------------------------------------------------------------- main sequence

   initial begin : stimulus
      logic [sgrt_pkg::DATA_BITS-1:0] cfg_values [NUM_REGS];
      int unsigned                    counted;
      req_bus.valid       = 1'b0;
      req_bus.text_byte   = '0;
      req_bus.start_seq   = 1'b0;
      req_bus.end_of_text = 1'b0;
      psel    = 1'b0;
      penable = 1'b0;
      pwrite  = 1'b0;
      paddr   = '0;
      pwdata  = '0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Walk the directed table; switch to the directed register values partway.
      for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
         if (i == DIRECTED_CFG_ROW) begin
            drain_results();
            cfg_values[sgrt_pkg::REG_BASE]    = 32'h0000_03C5;
            cfg_values[sgrt_pkg::REG_TEXT]    = 32'h11;
            cfg_values[sgrt_pkg::REG_CODE]    = 32'h22;
            cfg_values[sgrt_pkg::REG_QUOTE]   = 32'h33;
            cfg_values[sgrt_pkg::REG_ALARM]   = 32'h44;
            cfg_values[sgrt_pkg::REG_STRING]  = 32'h55;
            cfg_values[sgrt_pkg::REG_COMMENT] = 32'h66;
            cfg_values[sgrt_pkg::REG_KEYWORD] = 32'h77;
            program_registers(cfg_values);
         end
         send_request(DIRECTED_ROWS[i].req, DIRECTED_ROWS[i].typed, DIRECTED_ROWS[i].want);
      end

      // Random phases: all ones, all zeros, then random wide values. Registers change
      // only with the block idle.
      for (int phase = 0; phase < PHASES; phase++) begin
         drain_results();
         for (int k = sgrt_pkg::REG_BASE; k <= sgrt_pkg::REG_KEYWORD; k++)
            cfg_values[k] = (phase == 0) ? '1 : (phase == 1) ? '0 : $urandom;
         program_registers(cfg_values);
         // Hold the receiver off while requests keep coming so the block backs up.
         if (phase == 2 || phase == 4)
            hold_off_req = 1'b1;
         counted = 0;
         while (counted < PHASE_ITEMS) begin
            if ($urandom_range(0, 2) == 0)
               send_noise();
            send_random_sequence(counted);
         end
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_styles.size() == 0)
         $display("sgr_escape_style_tracker: match");
      else
         $display("sgr_escape_style_tracker: mismatch");
      $finish;
   end

   // ---------------------------------------------------------------- result side

   // Receiver: switch between random stall patterns; serve hold-off requests.
   initial begin : result_sink
      int unsigned mode;
      int unsigned mode_left;
      int unsigned tick;
      mode      = 0;
      mode_left = 0;
      tick      = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_req) begin
            rsp_bus.ready <= 1'b0;
            for (int c = 0; c < HOLD_CYCLES; c++)
               @(posedge clock);
            hold_off_req = 1'b0;
         end
         if (mode_left == 0) begin
            mode      = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 300);
         end
         mode_left--;
         tick++;
         case (mode)
            0: rsp_bus.ready <= 1'b1;
            1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
            2: rsp_bus.ready <= (tick % 3 == 0);
            default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   // Compare each accepted result with the oldest prediction.
   always @(posedge clock) begin : result_check
      style_result_type got;
      style_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.style.bold      = rsp_bus.bold;
         got.style.dim       = rsp_bus.dim;
         got.style.italic    = rsp_bus.italic;
         got.style.underline = rsp_bus.underline;
         got.style.pair      = rsp_bus.color_pair;
         got.seq_done        = rsp_bus.seq_done;
         if (pending_styles.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("ERROR: result with no request waiting: %p", got);
         end else begin
            want = pending_styles.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display("ERROR: style b%0b d%0b i%0b u%0b pair %h done %0b, %s",
                           got.style.bold, got.style.dim, got.style.italic,
                           got.style.underline, got.style.pair, got.seq_done,
                           $sformatf("expected b%0b d%0b i%0b u%0b pair %h done %0b",
                                     want.style.bold, want.style.dim, want.style.italic,
                                     want.style.underline, want.style.pair,
                                     want.seq_done));
            end
         end
      end
   end

   initial begin : watchdog
      #(LIMIT_NS);
      $display("sgr_escape_style_tracker: mismatch");
      $finish;
   end

endmodule

>>> filelist.f
hw/rtl/sgrt_pkg.sv
hw/rtl/sgrt_req_if.sv
hw/rtl/sgrt_rsp_if.sv
hw/rtl/sgrt_csr.sv
hw/rtl/sgr_escape_style_tracker.sv
tb/sgr_escape_style_tracker_tb.sv
